// File: hdl/fss_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the Fibonacci search sorted store.
// No dependencies; used by every other file of the block.
package fss_pkg;

  localparam int STORE_DEPTH   = 1024;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  // element_count register width (fixed by the register definition)
  localparam int N_W           = 11;
  // smallest Fibonacci number at or above n stays below 2n
  localparam int FIB_W         = N_W + 1;
  // base + f2 before clamping
  localparam int SUM_W         = FIB_W + 1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ADDR_W-1:0] index;
  } result_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_CHECK = 6'b000100,
    S_CMP   = 6'b001000,
    S_FINAL = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// File: hdl/fibonacci_search_sorted_store_unit.sv
`timescale 1ns / 1ps
// Fibonacci search over a sorted store of signed elements.
// Write transaction: stored at the accept edge, no result.
// Search transaction: Fibonacci setup steps, then probes (memory read, compare),
// then the final check and the hand-off of the result (an empty store goes straight
// to the hand-off), one search at a time.
// Reset clears control state and element_count; the store holds garbage until written.
module fibonacci_search_sorted_store_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration: element_count
  input  logic                                     cfg_we,
  input  logic [fss_pkg::N_W-1:0]                  cfg_wdata,
  // input channel
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     func,
  input  logic [9:0]                               write_index,
  input  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] element_value,
  input  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] search_key,
  // output channel
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     found,
  output logic [9:0]                               match_index
);

  logic [fss_pkg::N_W-1:0]    element_count;
  logic [fss_pkg::N_W-1:0]    count_n;
  logic                       in_accept;
  logic                       wr_en;
  logic                       search_start;
  logic                       rd_en;
  logic [fss_pkg::ADDR_W-1:0] rd_addr;
  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] rd_data;
  fss_pkg::result_t           res;
  logic                       res_take;
  logic                       busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_we) begin
      element_count <= cfg_wdata;
    end
  end

  // clamp the count to the store depth
  assign count_n = (element_count > fss_pkg::N_W'(fss_pkg::STORE_DEPTH)) ?
                   fss_pkg::N_W'(fss_pkg::STORE_DEPTH) : element_count;

  // hold off new transactions while a search runs or its result waits
  assign in_stall     = busy;
  assign in_accept    = in_valid && !in_stall;
  assign wr_en        = in_accept && (func == fss_pkg::FUNC_WRITE);
  assign search_start = in_accept && (func == fss_pkg::FUNC_SEARCH);

  fss_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fss_pkg::ADDR_W'(write_index)),
    .wdata (element_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (search_start),
    .key_in   (search_key),
    .count_n  (count_n),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res      (res),
    .res_take (res_take)
  );

  // output register: take a new result when empty or being drained
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      found       <= res.found;
      match_index <= 10'(res.index);
    end
  end

  // a miss always reports index zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_index == '0)
    else $error("miss reported with nonzero index");

  // a hit lies inside the elements in use
  assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> fss_pkg::N_W'(match_index) < count_n)
    else $error("hit index beyond element count");

  // the store is only read while a search is in flight
  assert property (@(posedge clk) disable iff (rst)
    rd_en |-> in_stall)
    else $error("store read while idle");

  // a handed-off result shows up on the output next cycle
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res_take |=> out_valid)
    else $error("result lost at output register");

endmodule

// File: hdl/fss_store.sv
`timescale 1ns / 1ps
// Element store: one write port, one read port with registered read data.
// Depends on fss_pkg for depth and element width.
module fss_store (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [fss_pkg::ADDR_W-1:0]             waddr,
  input  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] wdata,
  input  logic                                   re,
  input  logic [fss_pkg::ADDR_W-1:0]             raddr,
  output logic signed [fss_pkg::ELEMENT_WIDTH-1:0] rdata
);

  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] mem [fss_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/fss_ctrl.sv
`timescale 1ns / 1ps
// Search sequencer: Fibonacci setup, probe/compare loop and final check.
// Depends on fss_pkg; reads the element store through one read port.
module fss_ctrl (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] key_in,
  input  logic [fss_pkg::N_W-1:0]                  count_n,
  output logic                                     busy,
  output logic                                     rd_en,
  output logic [fss_pkg::ADDR_W-1:0]               rd_addr,
  input  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] rd_data,
  output fss_pkg::result_t                         res,
  input  logic                                     res_take
);

  fss_pkg::state_t state;

  logic signed [fss_pkg::ELEMENT_WIDTH-1:0] key;
  logic [fss_pkg::N_W-1:0]    n;
  logic [fss_pkg::FIB_W-1:0]  f2, f1, fm;
  logic [fss_pkg::N_W-1:0]    base;     // offset + 1
  logic [fss_pkg::ADDR_W-1:0] probe;
  logic [fss_pkg::ADDR_W-1:0] where;
  logic                       hit;

  logic [fss_pkg::SUM_W-1:0]  sum;
  logic [fss_pkg::ADDR_W-1:0] probe_idx;
  logic                       loop_on;
  logic                       final_ok;
  logic [fss_pkg::N_W-1:0]    probe_inc;

  // probe position offset + f2, clamped to [0, n-1]
  always_comb begin
    sum = fss_pkg::SUM_W'(base) + fss_pkg::SUM_W'(f2);
    if (sum == '0) begin
      probe_idx = '0;
    end else if (sum > fss_pkg::SUM_W'(n)) begin
      probe_idx = fss_pkg::ADDR_W'(n - fss_pkg::N_W'(1));
    end else begin
      probe_idx = fss_pkg::ADDR_W'(sum - fss_pkg::SUM_W'(1));
    end
  end

  assign loop_on   = (fm > fss_pkg::FIB_W'(1));
  assign final_ok  = (f1 != '0) && (base < n);
  assign probe_inc = fss_pkg::N_W'(probe) + fss_pkg::N_W'(1);

  assign busy    = (state != fss_pkg::S_IDLE);
  assign rd_en   = (state == fss_pkg::S_CHECK) && (loop_on || final_ok);
  assign rd_addr = loop_on ? probe_idx : base[fss_pkg::ADDR_W-1:0];

  assign res.valid = (state == fss_pkg::S_DONE);
  assign res.found = hit;
  assign res.index = hit ? where : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fss_pkg::S_IDLE;
      hit   <= 1'b0;
    end else begin
      case (state)
        fss_pkg::S_IDLE: begin
          if (start) begin
            key  <= key_in;
            n    <= count_n;
            f2   <= '0;
            f1   <= fss_pkg::FIB_W'(1);
            fm   <= fss_pkg::FIB_W'(1);
            base <= '0;
            hit  <= 1'b0;
            state <= (count_n == '0) ? fss_pkg::S_DONE : fss_pkg::S_SETUP;
          end
        end
        fss_pkg::S_SETUP: begin
          // one Fibonacci step per cycle until fm >= n
          if (fm < fss_pkg::FIB_W'(n)) begin
            f2 <= f1;
            f1 <= fm;
            fm <= f1 + fm;
          end else begin
            state <= fss_pkg::S_CHECK;
          end
        end
        fss_pkg::S_CHECK: begin
          if (loop_on) begin
            probe <= probe_idx;
            state <= fss_pkg::S_CMP;
          end else if (final_ok) begin
            state <= fss_pkg::S_FINAL;
          end else begin
            state <= fss_pkg::S_DONE;
          end
        end
        fss_pkg::S_CMP: begin
          if (rd_data < key) begin
            fm   <= f1;
            f1   <= f2;
            f2   <= f1 - f2;
            base <= probe_inc;
            state <= fss_pkg::S_CHECK;
          end else if (rd_data > key) begin
            fm <= f2;
            f1 <= f1 - f2;
            f2 <= (f2 << 1) - f1;
            state <= fss_pkg::S_CHECK;
          end else begin
            hit   <= 1'b1;
            where <= probe;
            state <= fss_pkg::S_DONE;
          end
        end
        fss_pkg::S_FINAL: begin
          if (rd_data == key) begin
            hit   <= 1'b1;
            where <= base[fss_pkg::ADDR_W-1:0];
          end
          state <= fss_pkg::S_DONE;
        end
        fss_pkg::S_DONE: begin
          if (res_take) begin
            state <= fss_pkg::S_IDLE;
          end
        end
        default: begin
          state <= fss_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
